/* hw/rtl/u2a_pkg.sv */
// Shared types, constants and the replacement table for the UTF-8 to ASCII
// transliterator. No dependencies; used by every module of the block.
`default_nettype none

package u2a_pkg;

  localparam int unsigned BufSizeMax = 4096;
  localparam int unsigned CapW       = 13;
  localparam int unsigned CountW     = 12;
  localparam int unsigned CodeW      = 21;
  localparam int unsigned MaxResults = 4;

  // Code points with their own replacement
  localparam logic [CodeW-1:0] CpLsquo  = 21'h02018;
  localparam logic [CodeW-1:0] CpRsquo  = 21'h02019;
  localparam logic [CodeW-1:0] CpLdquo  = 21'h0201C;
  localparam logic [CodeW-1:0] CpRdquo  = 21'h0201D;
  localparam logic [CodeW-1:0] CpEnDash = 21'h02013;
  localparam logic [CodeW-1:0] CpEmDash = 21'h02014;
  localparam logic [CodeW-1:0] CpEllip  = 21'h02026;
  localparam logic [CodeW-1:0] CpNbsp   = 21'h000A0;

  localparam logic [7:0] ChApos  = 8'h27;
  localparam logic [7:0] ChQuot  = 8'h22;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQmark = 8'h3F;
  localparam logic [7:0] ChNul   = 8'h00;

  typedef struct packed {
    logic [1:0] cnt;  // 1 or 3 characters
    logic [7:0] ch;   // the character, repeated cnt times
  } u2a_repl_t;

  // One queued unit of output work: up to four results for one input byte
  typedef struct packed {
    logic [MaxResults-1:0][7:0] ch;
    logic [2:0]                 cnt;   // results in this transaction group, 1..4
    logic                       term;  // last result is the terminator
  } u2a_job_t;

  function automatic u2a_repl_t repl_lookup(input logic [CodeW-1:0] code);
    u2a_repl_t r;
    r.cnt = 2'd1;
    r.ch  = ChQmark;
    case (code)
      CpLsquo, CpRsquo:   r.ch = ChApos;
      CpLdquo, CpRdquo:   r.ch = ChQuot;
      CpEnDash, CpEmDash: r.ch = ChDash;
      CpEllip: begin
        r.cnt = 2'd3;
        r.ch  = ChDot;
      end
      CpNbsp:             r.ch = ChSpace;
      default:            r.ch = ChQmark;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/u2a_front.sv */
// Front end: takes input bytes, runs the UTF-8 decode state and the output
// cap, and builds at most one job per byte. Depends on u2a_pkg.
`default_nettype none

module u2a_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [12:0]             cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [7:0]              data_byte_i,
  input  wire logic                    q_full_i,
  output logic                         push_o,
  output u2a_pkg::u2a_job_t            job_o
);

  logic [u2a_pkg::CapW-1:0]   buf_size_q;
  logic [1:0]                 rem_q, rem_d;
  logic [u2a_pkg::CodeW-1:0]  acc_q, acc_d;
  logic [u2a_pkg::CountW-1:0] wc_q, wc_d;

  logic                       accept;
  logic                       pend, cont_path, do_flush, tail_char, term;
  logic [1:0]                 rem_dec, extra;
  logic [u2a_pkg::CodeW-1:0]  acc_shift, flush_code;
  u2a_pkg::u2a_repl_t         repl;
  logic [1:0]                 fcnt;
  logic [2:0]                 k, avail, m;
  logic [u2a_pkg::CapW-1:0]   cap, wc_ext, avail_full;
  logic                       room;
  logic [7:0]                 lead_bits;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign pend      = (rem_q != 2'd0);
  assign cont_path = pend && (data_byte_i[7:6] == 2'b10);
  assign rem_dec   = rem_q - 2'd1;
  assign acc_shift = {acc_q[u2a_pkg::CodeW-7:0], data_byte_i[5:0]};

  always_comb begin
    if (cont_path) begin
      do_flush   = (rem_dec == 2'd0);
      flush_code = acc_shift;
    end else begin
      do_flush   = pend;
      flush_code = acc_q;
    end
  end

  assign repl      = u2a_pkg::repl_lookup(flush_code);
  assign fcnt      = do_flush ? repl.cnt : 2'd0;
  assign tail_char = !cont_path && (data_byte_i != 8'h00) && !data_byte_i[7];
  assign term      = !cont_path && (data_byte_i == 8'h00) && (buf_size_q != '0);
  assign k         = {1'b0, fcnt} + {2'b00, tail_char};

  // Room left under the cap, saturated at four
  assign cap        = (buf_size_q > u2a_pkg::CapW'(u2a_pkg::BufSizeMax)) ?
                      u2a_pkg::CapW'(u2a_pkg::BufSizeMax) : buf_size_q;
  assign wc_ext     = {1'b0, wc_q};
  assign room       = (cap != '0) && ((wc_ext + 13'd1) < cap);
  assign avail_full = cap - 13'd1 - wc_ext;
  assign avail      = !room ? 3'd0 :
                      (avail_full >= 13'd4) ? 3'd4 : avail_full[2:0];
  assign m          = (k < avail) ? k : avail;

  always_comb begin
    for (int i = 0; i < u2a_pkg::MaxResults; i++) begin
      if (3'(i) < m) begin
        job_o.ch[i] = (3'(i) < {1'b0, fcnt}) ? repl.ch : data_byte_i;
      end else begin
        job_o.ch[i] = u2a_pkg::ChNul;
      end
    end
    job_o.cnt  = m + {2'b00, term};
    job_o.term = term;
  end

  assign push_o = accept && (job_o.cnt != 3'd0);

  always_comb begin
    if (data_byte_i >= 8'hF0) begin
      extra = 2'd3;
    end else if (data_byte_i >= 8'hE0) begin
      extra = 2'd2;
    end else begin
      extra = 2'd1;
    end
    case (extra)
      2'd3:    lead_bits = data_byte_i & 8'h07;
      2'd2:    lead_bits = data_byte_i & 8'h0F;
      default: lead_bits = data_byte_i & 8'h1F;
    endcase
  end

  always_comb begin
    rem_d = rem_q;
    acc_d = acc_q;
    wc_d  = wc_q;
    if (accept) begin
      wc_d = wc_q + u2a_pkg::CountW'(m);
      if (cont_path) begin
        rem_d = rem_dec;
        acc_d = (rem_dec == 2'd0) ? '0 : acc_shift;
      end else if (data_byte_i == 8'h00) begin
        rem_d = 2'd0;
        acc_d = '0;
        wc_d  = '0;
      end else if (!data_byte_i[7]) begin
        rem_d = 2'd0;
        acc_d = '0;
      end else begin
        rem_d = extra;
        acc_d = u2a_pkg::CodeW'(lead_bits);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_size_q <= 13'd64;
      rem_q      <= 2'd0;
      acc_q      <= '0;
      wc_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        buf_size_q <= cfg_wdata_i;
      end
      rem_q <= rem_d;
      acc_q <= acc_d;
      wc_q  <= wc_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/u2a_queue.sv */
// Short job queue between the front end and the output sequencer.
// Depends on u2a_pkg for the job type.
`default_nettype none

module u2a_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  u2a_pkg::u2a_job_t       job_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output u2a_pkg::u2a_job_t       job_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  u2a_pkg::u2a_job_t mem_q [DEPTH];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/u2a_back.sv */
// Output sequencer: walks the results of the head job one per cycle, when not
// stalled, into a registered output stage. Depends on u2a_pkg for the job type.
`default_nettype none

module u2a_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_empty_i,
  input  u2a_pkg::u2a_job_t       job_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              out_char_o,
  output logic                    is_terminator_o,
  output logic                    run_last_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] char_q;
  logic       term_q, last_q;
  logic       load, last;

  assign load  = !q_empty_i && (!valid_q || out_ready_i);
  assign last  = ({1'b0, idx_q} == (job_i.cnt - 3'd1));
  assign pop_o = load && last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = last ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // Payload: load only, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= job_i.ch[idx_q];
      term_q <= job_i.term && last;
      last_q <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign out_char_o      = char_q;
  assign is_terminator_o = term_q;
  assign run_last_o      = last_q;

endmodule

`default_nettype wire

/* hw/rtl/utf8_to_ascii_transliterator_core.sv */
// UTF-8 to ASCII transliterator, top level.
// Usage:
//   Input channel: one UTF-8 byte per transaction on data_byte_i
//   (in_valid_i / in_ready_o); a zero byte ends the string.
//   Output channel: zero to four results per input byte on out_char_o,
//   is_terminator_o and run_last_o (out_valid_o / out_ready_i); run_last_o
//   marks the last result of a byte. Bytes that cause no result (leads,
//   continuations mid-sequence, characters past the cap) produce nothing.
//   Config: cfg_we_i writes cfg_wdata_i to the buffer size (capacity
//   including the terminator, values above 4096 act as 4096).
//   A taken byte's job is written into the job queue; its first result then
//   loads the output register. Throughput: one result per cycle while
//   out_ready_i is high, set by the single output register; plain ASCII
//   passes at one byte per cycle then. Several results of one byte leave in
//   turn while the job queue keeps taking input until it fills.
//   Receiver stall: the output register holds; the queue absorbs up to
//   QUEUE_DEPTH jobs, after that in_ready_o drops.
//   Reset: decode state and character count clear, buffer size is 64, the
//   queue and output are empty.
// Depends on u2a_pkg, u2a_front, u2a_queue, u2a_back.
`default_nettype none

module utf8_to_ascii_transliterator_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [12:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_char_o,
  output logic             is_terminator_o,
  output logic             run_last_o
);

  u2a_pkg::u2a_job_t push_job, head_job;
  logic              push, pop, q_full, q_empty;

  u2a_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  u2a_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .job_o   (head_job)
  );

  u2a_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .job_i           (head_job),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_char_o      (out_char_o),
    .is_terminator_o (is_terminator_o),
    .run_last_o      (run_last_o)
  );

  a_term_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_terminator_o |-> run_last_o)
    else $error("terminator not marked as last result");

  a_term_is_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_terminator_o |-> out_char_o == 8'h00)
    else $error("terminator carries a nonzero character");

  a_ascii_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_char_o[7])
    else $error("non-ASCII character emitted");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full && !pop |=> !q_empty)
    else $error("queue lost a job");

endmodule

`default_nettype wire
